FILE: design/cubic_root_bisection_unit_assert.svh
// Assertion macros for the cubic root bisection unit.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef CUBIC_ROOT_BISECTION_UNIT_ASSERT_SVH
`define CUBIC_ROOT_BISECTION_UNIT_ASSERT_SVH

// Check that is switched off while reset is high
`define CRB_ASSERT(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that also runs during reset
`define CRB_ASSERT_ALWAYS(name, clk, expr, msg) \
   name: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

FILE: design/crb_pkg.sv
// Shared types and constants of the cubic root bisection unit.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package crb_pkg;

   // Default data format: signed Q8.24
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 24;

   // Register and field widths
   localparam int TOL_W      = 31;
   localparam int ITER_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [TOL_W-1:0]  TOL_RESET      = 31'd17;
   localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd100;

   // Register index, taken from paddr[2]
   typedef enum logic {
      CSR_TOLERANCE = 1'b0,
      CSR_MAX_ITER  = 1'b1
   } csr_index_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_CONVERGED = 2'd0,
      STATUS_LIMIT     = 2'd1,
      STATUS_BAD       = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LO,
      ST_HI,
      ST_CMP,
      ST_STEP,
      ST_DONE
   } state_type;

   // Which point the shared evaluator is working on
   typedef enum logic [1:0] {
      TGT_LEFT,
      TGT_RIGHT,
      TGT_MID
   } target_type;

endpackage

`default_nettype wire

FILE: design/crb_req_if.sv
// Request channel (interval endpoints) of the cubic root bisection unit.
// Depends on crb_pkg for the default data width.
`timescale 1ns / 1ps
`default_nettype none

interface crb_req_if #(
   parameter int DATA_WIDTH = crb_pkg::DATA_WIDTH_DEFAULT
);
   import crb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] left_end;
   logic [DATA_WIDTH-1:0] right_end;

   modport source (output valid, output left_end, output right_end, input ready);
   modport sink   (input valid, input left_end, input right_end, output ready);

endinterface

`default_nettype wire

FILE: design/crb_rsp_if.sv
// Response channel (root, status, step count) of the cubic root bisection unit.
// Depends on crb_pkg for the default data width and field widths.
`timescale 1ns / 1ps
`default_nettype none

interface crb_rsp_if #(
   parameter int DATA_WIDTH = crb_pkg::DATA_WIDTH_DEFAULT
);
   import crb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] root;
   logic [STATUS_W-1:0]   status;
   logic [ITER_W-1:0]     iterations_used;

   modport source (output valid, output root, output status, output iterations_used,
                   input ready);
   modport sink   (input valid, input root, input status, input iterations_used,
                   output ready);

endinterface

`default_nettype wire

FILE: design/cubic_root_bisection_unit.sv
// Bisection root finder for f(x) = x^3 + x - 1, one request at a time.
// Each request first tests the sign of f at both endpoints, then runs steps
// (midpoint/stop test, then the sign of f on one shared FxF multiplier in 3
// passes); the result then goes into the output register.
// A new request is taken once the previous result reaches the output register.
// Reset (synchronous): sequencer idle, output empty, tolerance 17, limit 100.
`timescale 1ns / 1ps
`default_nettype none

`include "cubic_root_bisection_unit_assert.svh"

module cubic_root_bisection_unit #(
   parameter int DATA_WIDTH = crb_pkg::DATA_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = crb_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   crb_req_if.sink                              req_chan,
   crb_rsp_if.source                            rsp_chan,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [crb_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [crb_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [crb_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import crb_pkg::*;

   localparam int W      = DATA_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int EXT_W  = W + F;
   localparam int SUM_W  = W + 1;
   localparam int CMP_W  = (W + 1 > TOL_W + 2) ? W + 1 : TOL_W + 2;
   localparam int ACC_W  = 2 * F + 2;
   localparam logic [EXT_W-1:0] ONE_EXT     = EXT_W'(1) << F;
   localparam logic [EXT_W-1:0] NEG_ONE_EXT = ~ONE_EXT + EXT_W'(1);
   localparam logic [W-1:0]     BAD_ROOT    = NEG_ONE_EXT[W-1:0];

   // ---------------- registers ----------------
   state_type         state_ff,      state_in;
   target_type        target_ff,     target_in;
   logic [W-1:0]      left_ff,       left_in;
   logic [W-1:0]      right_ff,      right_in;
   logic [W-1:0]      mid_ff,        mid_in;
   logic              neg_left_ff,   neg_left_in;
   logic [F-1:0]      x_ff,          x_in;
   logic [2*F-1:0]    sq_ff,         sq_in;
   logic [2*F-1:0]    lo_ff,         lo_in;
   logic [2*F-1:0]    hi_ff,         hi_in;
   logic [ITER_W-1:0] iter_ff,       iter_in;
   logic [W-1:0]      res_root_ff,   res_root_in;
   status_type        res_status_ff, res_status_in;
   logic [ITER_W-1:0] res_iter_ff,   res_iter_in;
   logic              out_valid_ff,  out_valid_in;
   logic [W-1:0]      out_root_ff,   out_root_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [ITER_W-1:0] out_iter_ff,   out_iter_in;
   logic [TOL_W-1:0]  tol_ff,        tol_in;
   logic [ITER_W-1:0] max_ff,        max_in;

   // ---------------- combinational nets ----------------
   logic              csr_wr;
   csr_index_type     csr_index;
   logic [W-1:0]      eval_val;
   logic              eval_nonpos;
   logic [EXT_W-1:0]  eval_ext;
   logic              eval_big;
   logic [F-1:0]      eval_frac;
   logic [F-1:0]      mul_a;
   logic [F-1:0]      mul_b;
   logic [2*F-1:0]    mul_p;
   logic [ACC_W-1:0]  acc;
   logic              cube_neg;
   logic [SUM_W-1:0]  pair_sum;
   logic [W-1:0]      half_sum;
   logic [SUM_W-1:0]  pair_diff;
   logic              reversed;
   logic              narrow;
   logic [ITER_W-1:0] iter_next;
   logic              eval_done;
   logic              eval_neg;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[2]);

   always_comb begin
      tol_in = tol_ff;
      max_in = max_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_TOLERANCE: tol_in = pwdata[TOL_W-1:0];
            CSR_MAX_ITER:  max_in = pwdata[ITER_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_TOLERANCE: prdata = CSR_DATA_W'(tol_ff);
         CSR_MAX_ITER:  prdata = CSR_DATA_W'(max_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------- operand select and classification ----------------
   always_comb begin
      case (target_ff)
         TGT_LEFT:  eval_val = left_ff;
         TGT_RIGHT: eval_val = right_ff;
         default:   eval_val = mid_ff;
      endcase
   end

   // f < 0 for x <= 0, f > 0 for x >= 1.0; only 0 < x < 1.0 needs the cube
   assign eval_nonpos = eval_val[W-1] || (eval_val == '0);
   assign eval_ext    = {{F{1'b0}}, eval_val};
   assign eval_big    = |eval_ext[EXT_W-1:F];
   assign eval_frac   = eval_ext[F-1:0];

   // ---------------- shared multiplier ----------------
   always_comb begin
      case (state_ff)
         ST_LO: begin
            mul_a = sq_ff[F-1:0];
            mul_b = x_ff;
         end
         ST_HI: begin
            mul_a = sq_ff[2*F-1:F];
            mul_b = x_ff;
         end
         default: begin
            mul_a = eval_frac;
            mul_b = eval_frac;
         end
      endcase
   end

   assign mul_p = (2*F)'(mul_a) * (2*F)'(mul_b);

   // x^3 + x*2^2F < 2^3F  <=>  floor(x^3 / 2^F) + x*2^F < 2^2F
   assign acc = ACC_W'(hi_ff) + ACC_W'({x_ff, {F{1'b0}}}) + ACC_W'(lo_ff[2*F-1:F]);
   assign cube_neg = (acc[ACC_W-1:2*F] == 2'b00);

   // ---------------- midpoint and stop test ----------------
   assign pair_sum  = {left_ff[W-1], left_ff} + {right_ff[W-1], right_ff};
   assign half_sum  = pair_sum[W:1];
   assign pair_diff = {right_ff[W-1], right_ff} - {left_ff[W-1], left_ff};
   assign reversed  = $signed(right_ff) < $signed(left_ff);
   assign narrow    = reversed || (CMP_W'(pair_diff) < CMP_W'({tol_ff, 1'b0}));
   assign iter_next = iter_ff + ITER_W'(1);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mid_in        = mid_ff;
      neg_left_in   = neg_left_ff;
      x_in          = x_ff;
      sq_in         = sq_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      iter_in       = iter_ff;
      res_root_in   = res_root_ff;
      res_status_in = res_status_ff;
      res_iter_in   = res_iter_ff;
      out_valid_in  = out_valid_ff;
      out_root_in   = out_root_ff;
      out_status_in = out_status_ff;
      out_iter_in   = out_iter_ff;
      eval_done     = 1'b0;
      eval_neg      = 1'b0;

      // output register drains on handshake
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               left_in   = req_chan.left_end;
               right_in  = req_chan.right_end;
               target_in = TGT_LEFT;
               iter_in   = '0;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_nonpos) begin
               eval_done = 1'b1;
               eval_neg  = 1'b1;
            end else if (eval_big) begin
               eval_done = 1'b1;
               eval_neg  = 1'b0;
            end else begin
               x_in     = eval_frac;
               sq_in    = mul_p;
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            lo_in    = mul_p;
            state_in = ST_HI;
         end
         ST_HI: begin
            hi_in    = mul_p;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            eval_done = 1'b1;
            eval_neg  = cube_neg;
         end
         ST_STEP: begin
            mid_in  = half_sum;
            iter_in = iter_next;
            if (narrow) begin
               res_root_in   = half_sum;
               res_status_in = STATUS_CONVERGED;
               res_iter_in   = iter_next;
               state_in      = ST_DONE;
            end else begin
               target_in = TGT_MID;
               state_in  = ST_EVAL;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in  = 1'b1;
               out_root_in   = res_root_ff;
               out_status_in = res_status_ff;
               out_iter_in   = res_iter_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // act on a finished sign evaluation
      if (eval_done) begin
         case (target_ff)
            TGT_LEFT: begin
               neg_left_in = eval_neg;
               target_in   = TGT_RIGHT;
               state_in    = ST_EVAL;
            end
            TGT_RIGHT: begin
               if (eval_neg == neg_left_ff) begin
                  res_root_in   = BAD_ROOT;
                  res_status_in = STATUS_BAD;
                  res_iter_in   = '0;
                  state_in      = ST_DONE;
               end else if (max_ff == '0) begin
                  res_root_in   = '0;
                  res_status_in = STATUS_LIMIT;
                  res_iter_in   = '0;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_STEP;
               end
            end
            default: begin
               if (neg_left_ff != eval_neg) begin
                  right_in = mid_ff;
               end else begin
                  left_in     = mid_ff;
                  neg_left_in = eval_neg;
               end
               if (iter_ff == max_ff) begin
                  res_root_in   = mid_ff;
                  res_status_in = STATUS_LIMIT;
                  res_iter_in   = max_ff;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_STEP;
               end
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TGT_LEFT;
         out_valid_ff <= 1'b0;
         tol_ff       <= TOL_RESET;
         max_ff       <= MAX_ITER_RESET;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         out_valid_ff <= out_valid_in;
         tol_ff       <= tol_in;
         max_ff       <= max_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      right_ff      <= right_in;
      mid_ff        <= mid_in;
      neg_left_ff   <= neg_left_in;
      x_ff          <= x_in;
      sq_ff         <= sq_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      iter_ff       <= iter_in;
      res_root_ff   <= res_root_in;
      res_status_ff <= res_status_in;
      res_iter_ff   <= res_iter_in;
      out_root_ff   <= out_root_in;
      out_status_ff <= out_status_in;
      out_iter_ff   <= out_iter_in;
   end

   // ---------------- channel outputs ----------------
   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.root            = out_root_ff;
   assign rsp_chan.status          = out_status_ff;
   assign rsp_chan.iterations_used = out_iter_ff;

   // ---------------- assertions ----------------
   `CRB_ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> (!out_valid_ff && state_ff == ST_IDLE),
      "reset did not clear the sequencer")
   `CRB_ASSERT(a_start_left, clock, reset,
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_EVAL && target_ff == TGT_LEFT),
      "request did not start at the left end")
   `CRB_ASSERT(a_cube_operand, clock, reset,
      (state_ff == ST_LO) |-> (x_ff != '0),
      "cube path entered with a zero operand")
   `CRB_ASSERT(a_bad_fields, clock, reset,
      (out_valid_ff && out_status_ff == STATUS_BAD) |->
         (out_iter_ff == '0 && out_root_ff == BAD_ROOT),
      "bad interval result fields wrong")
   `CRB_ASSERT(a_conv_steps, clock, reset,
      (out_valid_ff && out_status_ff == STATUS_CONVERGED) |-> (out_iter_ff != '0),
      "converged with no step taken")

endmodule

`default_nettype wire

FILE: tb/tb_cubic_root_bisection_unit.sv
// Self-checking testbench for the cubic root bisection unit.
// Needs crb_pkg, crb_req_if, crb_rsp_if and cubic_root_bisection_unit.
// Drives intervals with random gaps, predicts each root and checks each response.
`timescale 1ns / 1ps

module tb_cubic_root_bisection_unit;
   import crb_pkg::*;

   localparam int DW   = DATA_WIDTH_DEFAULT;
   localparam int FRAC = FRAC_BITS_DEFAULT;
   // Fixed point value closest to the real root 0.6823278...
   localparam logic signed [DW-1:0] ROOT_NEAR = 32'sd11447561;

   typedef struct {
      logic [DW-1:0] left_end;
      logic [DW-1:0] right_end;
   } interval_type;

   typedef struct {
      logic [DW-1:0]     root;
      status_type        status;
      logic [ITER_W-1:0] iterations_used;
   } root_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   wire  [CSR_DATA_W-1:0] prdata;
   wire                   pready;

   crb_req_if #(.DATA_WIDTH(DW)) req_if ();
   crb_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

   cubic_root_bisection_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Local copy of the registers
   logic [TOL_W-1:0]  tol_cfg   = TOL_RESET;
   logic [ITER_W-1:0] limit_cfg = MAX_ITER_RESET;

   interval_type    intervals_pending[$];
   root_result_type expected_roots[$];
   interval_type    next_interval;
   int unsigned     intervals_sent = 0;
   int unsigned     roots_seen     = 0;
   int unsigned     fault_count    = 0;
   bit              quiet_stretch  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.left_end  = '0;
      req_if.right_end = '0;
      rsp_if.ready     = 1'b0;
   end

   // Sign of f(x) = x^3 + x - 1, exact at full width
   function automatic logic f_below_zero(logic signed [DW-1:0] x);
      logic signed [127:0] xw;
      logic signed [127:0] val;
      xw  = 128'(x);
      val = xw * xw * xw + (xw <<< (2 * FRAC)) - (128'sd1 <<< (3 * FRAC));
      return val < 0;
   endfunction

   // Bisection under the current register values
   function automatic root_result_type predict_root(logic signed [DW-1:0] lo,
                                                    logic signed [DW-1:0] hi);
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      logic signed [DW-1:0] m;
      logic signed [DW+1:0] sum;
      logic                 na;
      logic                 nm;
      longint               span;
      longint               twice_tol;
      int                   step;
      root_result_type      r;
      a  = lo;
      b  = hi;
      m  = '0;
      na = f_below_zero(a);
      if (na == f_below_zero(b)) begin
         r.root            = -(DW'(1) << FRAC);
         r.status          = STATUS_BAD;
         r.iterations_used = '0;
         return r;
      end
      twice_tol = 2 * longint'(tol_cfg);
      for (step = 1; step <= int'(limit_cfg); step++) begin
         sum = (DW+2)'(a) + (DW+2)'(b);
         m   = sum[DW:1];
         nm  = f_below_zero(m);
         // reversed interval gives a negative span and stops at once
         span = longint'(b) - longint'(a);
         if (span < twice_tol) begin
            r.root            = m;
            r.status          = STATUS_CONVERGED;
            r.iterations_used = step[ITER_W-1:0];
            return r;
         end
         if (na != nm) begin
            b = m;
         end else begin
            a  = m;
            na = nm;
         end
      end
      r.root            = m;
      r.status          = STATUS_LIMIT;
      r.iterations_used = limit_cfg;
      return r;
   endfunction

   function automatic logic signed [DW-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[DW-1:0];
   endfunction

   function automatic longint wide_offset();
      int unsigned k;
      k = $urandom_range(0, 32);
      return longint'({$urandom}) & ((64'sd1 <<< k) - 1);
   endfunction

   function automatic logic [DW-1:0] pick_extreme();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'h00000000;
         3: return 32'h01000000;
         4: return 32'hFF000000;
         5: return ROOT_NEAR;
         6: return ROOT_NEAR + 1;
         default: return ROOT_NEAR - 1;
      endcase
   endfunction

   // Mostly intervals around the root, some reversed, some noise
   function automatic interval_type random_interval();
      int unsigned   kind;
      interval_type  iv;
      logic [DW-1:0] swap;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         iv.left_end  = clamp32(longint'(ROOT_NEAR) - wide_offset());
         iv.right_end = clamp32(longint'(ROOT_NEAR) + wide_offset());
         if (kind >= 45) begin
            swap         = iv.left_end;
            iv.left_end  = iv.right_end;
            iv.right_end = swap;
         end
      end else if (kind < 80) begin
         iv.left_end  = $urandom;
         iv.right_end = $urandom;
      end else if (kind < 92) begin
         iv.left_end  = pick_extreme();
         iv.right_end = pick_extreme();
      end else begin
         iv.left_end  = (kind < 96) ? pick_extreme() : $urandom;
         iv.right_end = iv.left_end;
      end
      return iv;
   endfunction

   task automatic push_interval(logic [DW-1:0] l, logic [DW-1:0] r);
      intervals_pending.push_back('{l, r});
      intervals_sent++;
   endtask

   task automatic push_random(int unsigned n);
      interval_type iv;
      repeat (n) begin
         iv = random_interval();
         push_interval(iv.left_end, iv.right_end);
      end
   endtask

   task automatic wait_drained();
      while (roots_seen < intervals_sent) @(posedge clock);
   endtask

   // APB write: setup cycle, then access until pready
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == CSR_TOLERANCE) tol_cfg = data[TOL_W-1:0];
      else limit_cfg = data[ITER_W-1:0];
   endtask

   // Upper bits carry junk to exercise the register masks
   task automatic set_config(logic [TOL_W-1:0] tol, logic [ITER_W-1:0] lim);
      write_csr(CSR_TOLERANCE, {1'($urandom), tol});
      write_csr(CSR_MAX_ITER, {24'($urandom), lim});
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_roots.push_back(predict_root(req_if.left_end, req_if.right_end));
         end
         if (!req_if.valid || req_if.ready) begin
            if (intervals_pending.size() != 0 &&
                (quiet_stretch || $urandom_range(0, 99) >= 34)) begin
               next_interval     = intervals_pending.pop_front();
               req_if.valid     <= 1'b1;
               req_if.left_end  <= next_interval.left_end;
               req_if.right_end <= next_interval.right_end;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            roots_seen++;
            if (expected_roots.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected response: root %h status %0d steps %0d",
                           rsp_if.root, rsp_if.status, rsp_if.iterations_used);
               fault_count++;
            end else if (expected_roots[0].root !== rsp_if.root ||
                         expected_roots[0].status !== rsp_if.status ||
                         expected_roots[0].iterations_used !== rsp_if.iterations_used) begin
               if (fault_count < 10)
                  $display({"mismatch: root exp %h got %h, status exp %0d got %0d,",
                            " steps exp %0d got %0d"},
                           expected_roots[0].root, rsp_if.root,
                           expected_roots[0].status, rsp_if.status,
                           expected_roots[0].iterations_used, rsp_if.iterations_used);
               fault_count++;
               void'(expected_roots.pop_front());
            end else begin
               void'(expected_roots.pop_front());
            end
         end
         rsp_if.ready <= quiet_stretch || ($urandom_range(0, 99) >= 34);
      end
   end

   // Stimulus sequence
   initial begin
      int unsigned p;
      logic [TOL_W-1:0] tol;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed intervals at reset settings
      push_interval(32'h00000000, 32'h01000000);
      push_interval(32'h80000000, 32'h7FFFFFFF);
      push_interval(32'h7FFFFFFF, 32'h80000000);
      push_interval(32'h01000000, 32'h00000000);
      push_interval(32'h00000000, 32'h00000000);
      push_interval(32'h7FFFFFFF, 32'h7FFFFFFF);
      push_interval(32'h80000000, 32'h80000000);
      push_interval(32'h01000000, 32'h7FFFFFFF);
      push_interval(32'h80000000, 32'h00000000);
      push_interval(32'h00800000, 32'h00C00000);
      push_interval(ROOT_NEAR, ROOT_NEAR + 1);
      push_interval(32'hFFFFFFFF, 32'h00000001);
      push_interval(32'hFFFFFFFF, 32'h01000000);
      push_interval(32'h00FFFFFF, 32'h01000001);
      push_interval(32'h80000000, 32'h01000000);
      push_interval(32'h00000000, 32'h7FFFFFFF);
      push_interval(32'hAAAAAAAA, 32'h55555555);
      push_interval(32'h55555555, 32'hAAAAAAAA);
      // half width right at the tolerance, then just under it
      push_interval(ROOT_NEAR - 17, ROOT_NEAR + 17);
      push_interval(ROOT_NEAR - 16, ROOT_NEAR + 17);
      wait_drained();

      // Zero tolerance: runs to the largest step limit
      set_config('0, 8'd255);
      push_random(10);
      wait_drained();

      // Largest tolerance, one step; full range is still too wide
      set_config({TOL_W{1'b1}}, 8'd1);
      push_interval(32'h80000000, 32'h7FFFFFFF);
      push_random(149);
      wait_drained();

      // No steps allowed
      set_config(TOL_W'(17), 8'd0);
      push_random(40);
      wait_drained();

      // Short limit, no idling on either side
      quiet_stretch = 1'b1;
      set_config(TOL_W'(17), 8'd20);
      push_random(300);
      wait_drained();
      quiet_stretch = 1'b0;

      // Random settings
      for (p = 0; p < 6; p++) begin
         case (p % 3)
            0: tol = TOL_W'($urandom_range(0, 255));
            1: tol = TOL_W'($urandom);
            default: tol = TOL_W'($urandom_range(0, 63));
         endcase
         set_config(tol, ITER_W'($urandom_range(1, 64)));
         push_random(180);
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (fault_count == 0 && expected_roots.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
